FILE: hw/rtl/periodic_timer_bank_core_macros.svh
// Assertion macros shared by the timer bank RTL.
`ifndef PERIODIC_TIMER_BANK_CORE_MACROS_SVH
`define PERIODIC_TIMER_BANK_CORE_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define PTB_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

   localparam int NUM_SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS       = 8;
   localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int PERIOD_W          = 32;

   typedef enum logic [2:0] {
      REQ_TICK       = 3'd0,
      REQ_CREATE     = 3'd1,
      REQ_SERVICE    = 3'd2,
      REQ_SET_ENABLE = 3'd3,
      REQ_CLEAR      = 3'd4,
      REQ_SET_PERIOD = 3'd5,
      REQ_READ_ALLOC = 3'd6,
      REQ_UNUSED     = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      EV_EXPIRY  = 2'd0,
      EV_SERVICE = 2'd1,
      EV_CREATE  = 2'd2,
      EV_ALLOC   = 2'd3
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [2:0]  slot;
      logic        ok;
      logic [3:0]  count;
   } rsp_type;

   typedef struct packed {
      logic                count_we;
      logic [PERIOD_W-1:0] count_next;
      logic                pending_next;
      logic                emit;
   } unit_result_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_OP    = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ptb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ptb_tick_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_tick_unit (
   input  wire logic                            is_service,
   input  wire logic                            enabled,
   input  wire logic                            pending,
   input  wire logic                            tick_hook,
   input  wire logic                            service_hook,
   input  wire logic [ptb_pkg::PERIOD_W-1:0]    count,
   input  wire logic [ptb_pkg::PERIOD_W-1:0]    period,
   output ptb_pkg::unit_result_type             result
);

   import ptb_pkg::*;

   logic [PERIOD_W-1:0] count_inc;

   assign count_inc = count + PERIOD_W'(1);

   always_comb begin
      result.count_we     = 1'b0;
      result.count_next   = count_inc;
      result.pending_next = pending;
      result.emit         = 1'b0;
      if (is_service) begin
         result.pending_next = 1'b0;
         result.emit         = pending & service_hook;
      end else if (enabled) begin
         result.count_we = 1'b1;
         if (count_inc >= period) begin
            result.count_next   = '0;
            result.pending_next = 1'b1;
            result.emit         = ~pending & tick_hook;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ptb_rsp_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire ptb_pkg::rsp_type push_item,
   input  wire logic             push_last,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_event_kind,
   output logic [2:0]            rsp_slot_index,
   output logic                  rsp_create_ok,
   output logic [3:0]            rsp_allocated_count,
   output logic                  rsp_last_event
);

   import ptb_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;
   logic    last_ff;

   assign busy     = valid_ff & rsp_stall;
   assign valid_in = push_valid | busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         item_ff <= push_item;
         last_ff <= push_last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_event_kind      = item_ff.kind;
   assign rsp_slot_index      = item_ff.slot;
   assign rsp_create_ok       = item_ff.ok;
   assign rsp_allocated_count = item_ff.count;
   assign rsp_last_event      = last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_timer_bank_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  type, index, enable, period, hook bits
// rsp_      out        rsp_valid/rsp_stall  kind, slot, ok, count, last flag
//
// A tick or service item walks the slots one per cycle through the shared tick unit,
// while no rsp_ stall holds it; other items use the op state, unknown items are dropped.
// Counts and intervals sit in two RAMs with a registered read, so the processed slot
// index is held in proc_idx_ff, a register behind its read address.
// Reset is synchronous and clears all control state and the slot flags.
// A stall on rsp_ holds the walk when a third result is found while two wait,
// and holds the final result in the flush state until the output register frees.

module periodic_timer_bank_core #(
   parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [2:0]  req_timer_index,
   input  wire logic        req_enable_bit,
   input  wire logic [31:0] req_period_value,
   input  wire logic        req_has_tick_hook,
   input  wire logic        req_has_service_hook,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_kind,
   output logic [2:0]       rsp_slot_index,
   output logic             rsp_create_ok,
   output logic [3:0]       rsp_allocated_count,
   output logic             rsp_last_event
);

   import ptb_pkg::*;

   `include "periodic_timer_bank_core_macros.svh"

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   state_type state_ff, state_in;

   logic [2:0]          rtype_ff, rtype_in;
   logic [2:0]          ridx_ff, ridx_in;
   logic                ren_ff, ren_in;
   logic [PERIOD_W-1:0] rper_ff, rper_in;
   logic                rth_ff, rth_in;
   logic                rsh_ff, rsh_in;

   logic [CNT_W-1:0]     alloc_ff, alloc_in;
   logic [NUM_SLOTS-1:0] enabled_ff, enabled_in;
   logic [NUM_SLOTS-1:0] pending_ff, pending_in;
   logic [NUM_SLOTS-1:0] thook_ff, thook_in;
   logic [NUM_SLOTS-1:0] shook_ff, shook_in;

   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]     proc_idx_ff, proc_idx_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;

   logic    hold_valid_ff, hold_valid_in;
   rsp_type hold_ff, hold_in;

   logic                cnt_we, per_we;
   logic [IDX_W-1:0]    cnt_waddr, per_waddr, rd_addr, rd_slot, alloc_slot, req_slot;
   logic [PERIOD_W-1:0] cnt_wdata, cnt_rdata, per_rdata;

   unit_result_type unit_res;
   logic            emit_now, advance, out_busy, addressed;
   logic            push_valid, push_last;
   rsp_type         push_item, walk_item;

   assign alloc_slot = alloc_ff[IDX_W-1:0];
   assign req_slot   = IDX_W'(ridx_ff);
   assign addressed  = 32'(ridx_ff) < 32'(alloc_ff);
   assign rd_slot    = (rd_idx_ff < CNT_W'(NUM_SLOTS)) ? rd_idx_ff[IDX_W-1:0] : '0;
   assign rd_addr    = (proc_valid_ff && !advance) ? proc_idx_ff : rd_slot;

   ptb_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   ptb_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (per_waddr),
      .wr_data (rper_ff),
      .rd_addr (rd_addr),
      .rd_data (per_rdata)
   );

   ptb_tick_unit u_tick_unit (
      .is_service   (rtype_ff == REQ_SERVICE),
      .enabled      (enabled_ff[proc_idx_ff]),
      .pending      (pending_ff[proc_idx_ff]),
      .tick_hook    (thook_ff[proc_idx_ff]),
      .service_hook (shook_ff[proc_idx_ff]),
      .count        (cnt_rdata),
      .period       (per_rdata),
      .result       (unit_res)
   );

   ptb_rsp_stage u_rsp_stage (
      .clock               (clock),
      .reset               (reset),
      .push_valid          (push_valid),
      .push_item           (push_item),
      .push_last           (push_last),
      .busy                (out_busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_create_ok       (rsp_create_ok),
      .rsp_allocated_count (rsp_allocated_count),
      .rsp_last_event      (rsp_last_event)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign emit_now  = proc_valid_ff && unit_res.emit && (n_ff < RES_CNT_W'(MAX_RESULTS));
   assign advance   = !(emit_now && hold_valid_ff && out_busy);

   always_comb begin
      walk_item.kind  = (rtype_ff == REQ_SERVICE) ? EV_SERVICE : EV_EXPIRY;
      walk_item.slot  = 3'(proc_idx_ff);
      walk_item.ok    = 1'b0;
      walk_item.count = 4'(alloc_ff);
   end

   always_comb begin
      state_in      = state_ff;
      rtype_in      = rtype_ff;
      ridx_in       = ridx_ff;
      ren_in        = ren_ff;
      rper_in       = rper_ff;
      rth_in        = rth_ff;
      rsh_in        = rsh_ff;
      alloc_in      = alloc_ff;
      enabled_in    = enabled_ff;
      pending_in    = pending_ff;
      thook_in      = thook_ff;
      shook_in      = shook_ff;
      rd_idx_in     = rd_idx_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      n_in          = n_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = proc_idx_ff;
      cnt_wdata     = unit_res.count_next;
      per_we        = 1'b0;
      per_waddr     = req_slot;
      push_valid    = 1'b0;
      push_item     = hold_ff;
      push_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rtype_in      = req_type;
               ridx_in       = req_timer_index;
               ren_in        = req_enable_bit;
               rper_in       = req_period_value;
               rth_in        = req_has_tick_hook;
               rsh_in        = req_has_service_hook;
               rd_idx_in     = '0;
               proc_valid_in = 1'b0;
               n_in          = '0;
               case (req_type)
                  REQ_TICK, REQ_SERVICE: state_in = ST_WALK;
                  REQ_CREATE, REQ_SET_ENABLE, REQ_CLEAR, REQ_SET_PERIOD,
                  REQ_READ_ALLOC: state_in = ST_OP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OP: begin
            state_in = ST_FLUSH;
            case (rtype_ff)
               REQ_CREATE: begin
                  hold_valid_in = 1'b1;
                  if (alloc_ff == CNT_W'(NUM_SLOTS)) begin
                     hold_in.kind  = EV_CREATE;
                     hold_in.slot  = '0;
                     hold_in.ok    = 1'b0;
                     hold_in.count = 4'(alloc_ff);
                  end else begin
                     per_we                 = 1'b1;
                     per_waddr              = alloc_slot;
                     cnt_we                 = 1'b1;
                     cnt_waddr              = alloc_slot;
                     cnt_wdata              = '0;
                     enabled_in[alloc_slot] = ren_ff;
                     thook_in[alloc_slot]   = rth_ff;
                     shook_in[alloc_slot]   = rsh_ff;
                     alloc_in               = alloc_ff + CNT_W'(1);
                     hold_in.kind           = EV_CREATE;
                     hold_in.slot           = 3'(alloc_ff);
                     hold_in.ok             = 1'b1;
                     hold_in.count          = 4'(alloc_ff + CNT_W'(1));
                  end
               end
               REQ_SET_ENABLE: begin
                  if (addressed) begin
                     enabled_in[req_slot] = ren_ff;
                  end
               end
               REQ_CLEAR: begin
                  if (addressed) begin
                     cnt_we    = 1'b1;
                     cnt_waddr = req_slot;
                     cnt_wdata = '0;
                  end
               end
               REQ_SET_PERIOD: begin
                  if (addressed) begin
                     per_we = 1'b1;
                  end
               end
               REQ_READ_ALLOC: begin
                  hold_valid_in = 1'b1;
                  hold_in.kind  = EV_ALLOC;
                  hold_in.slot  = '0;
                  hold_in.ok    = 1'b0;
                  hold_in.count = 4'(alloc_ff);
               end
               default: state_in = ST_FLUSH;
            endcase
         end
         ST_WALK: begin
            if (proc_valid_ff && advance) begin
               pending_in[proc_idx_ff] = unit_res.pending_next;
               cnt_we                  = unit_res.count_we;
               if (emit_now) begin
                  n_in          = n_ff + RES_CNT_W'(1);
                  hold_valid_in = 1'b1;
                  hold_in       = walk_item;
                  if (hold_valid_ff) begin
                     push_valid = 1'b1;
                  end
               end
            end
            if (advance) begin
               if (rd_idx_ff < CNT_W'(NUM_SLOTS)) begin
                  proc_valid_in = 1'b1;
                  proc_idx_in   = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in     = rd_idx_ff + CNT_W'(1);
               end else begin
                  proc_valid_in = 1'b0;
               end
            end
            if (!proc_valid_ff && rd_idx_ff == CNT_W'(NUM_SLOTS)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_busy) begin
               push_valid    = 1'b1;
               push_last     = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         alloc_ff      <= '0;
         enabled_ff    <= '0;
         pending_ff    <= '0;
         thook_ff      <= '0;
         shook_ff      <= '0;
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_ff      <= alloc_in;
         enabled_ff    <= enabled_in;
         pending_ff    <= pending_in;
         thook_ff      <= thook_in;
         shook_ff      <= shook_in;
         rd_idx_ff     <= rd_idx_in;
         proc_valid_ff <= proc_valid_in;
         n_ff          <= n_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff    <= rtype_in;
      ridx_ff     <= ridx_in;
      ren_ff      <= ren_in;
      rper_ff     <= rper_in;
      rth_ff      <= rth_in;
      rsh_ff      <= rsh_in;
      proc_idx_ff <= proc_idx_in;
      hold_ff     <= hold_in;
   end

   `PTB_ASSERT_ALWAYS(a_idle_hold_empty, (state_ff != ST_IDLE) || !hold_valid_ff, "Item held while idle")
   `PTB_ASSERT_ALWAYS(a_alloc_in_range, alloc_ff <= CNT_W'(NUM_SLOTS), "Allocation count beyond bank")
   `PTB_ASSERT_ALWAYS(a_push_only_when_free, !(push_valid && out_busy), "Result pushed into a full output")
   `PTB_ASSERT_NEXT(a_accept_leaves_idle,
      (state_ff == ST_IDLE) && req_valid && (req_type != REQ_UNUSED), state_ff != ST_IDLE,
      "Accepted item did not start")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ptb_pkg::*;

   localparam int SLOTS = NUM_SLOTS_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 480;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_AT = 200;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_AT = 300;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [2:0]  code;
      logic [2:0]  index;
      logic        enable;
      logic [31:0] period;
      logic        thook;
      logic        shook;
      bit          drain_first;
   } timer_req_type;

   typedef struct {
      ev_kind_type kind;
      logic [2:0]  slot;
      logic        ok;
      logic [3:0]  count;
      logic        last;
   } timer_event_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [2:0]  req_timer_index;
   logic        req_enable_bit;
   logic [31:0] req_period_value;
   logic        req_has_tick_hook;
   logic        req_has_service_hook;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [2:0]  rsp_slot_index;
   logic        rsp_create_ok;
   logic [3:0]  rsp_allocated_count;
   logic        rsp_last_event;

   // Timer bank state as the bench expects it to be.
   logic [31:0] tick_count_m [SLOTS];
   logic [31:0] period_m [SLOTS];
   bit          enabled_m [SLOTS];
   bit          pending_m [SLOTS];
   bit          tick_hook_m [SLOTS];
   bit          service_hook_m [SLOTS];
   int unsigned alloc_m;

   timer_req_type   request_q [$];
   timer_event_type hook_events_due [$];
   timer_req_type   offered;
   timer_event_type want;

   int errors;
   int total_items;
   int items_accepted;
   int cycles;
   int gap_left;
   int hold_left;
   bit long_hold_done;
   bit req_taken;

   periodic_timer_bank_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic timer_req_type req_item(logic [2:0] code, logic [2:0] index,
                                              logic enable, logic [31:0] period,
                                              logic thook, logic shook);
      timer_req_type r;
      r.code = code;
      r.index = index;
      r.enable = enable;
      r.period = period;
      r.thook = thook;
      r.shook = shook;
      r.drain_first = 1'b0;
      return r;
   endfunction

   function automatic timer_event_type slot_event(ev_kind_type kind, int slot, logic ok);
      timer_event_type ev;
      ev.kind = kind;
      ev.slot = slot[2:0];
      ev.ok = ok;
      ev.count = alloc_m[3:0];
      ev.last = 1'b0;
      return ev;
   endfunction

   // Applies one accepted item to the expected state and queues the events it causes.
   task automatic predict_timer_events(input timer_req_type r);
      timer_event_type evs [$];
      bit addressed;
      addressed = (r.index < alloc_m) && (r.index < SLOTS);
      case (r.code)
         REQ_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (enabled_m[i]) begin
                  tick_count_m[i] = tick_count_m[i] + 32'd1;
                  if (tick_count_m[i] >= period_m[i]) begin
                     tick_count_m[i] = '0;
                     if (!pending_m[i]) begin
                        pending_m[i] = 1'b1;
                        if (tick_hook_m[i] && evs.size() < MAX_RESULTS)
                           evs.push_back(slot_event(EV_EXPIRY, i, 1'b0));
                     end
                  end
               end
            end
         end
         REQ_CREATE: begin
            if (alloc_m >= SLOTS) begin
               evs.push_back(slot_event(EV_CREATE, 0, 1'b0));
            end else begin
               period_m[alloc_m] = r.period;
               enabled_m[alloc_m] = r.enable;
               tick_hook_m[alloc_m] = r.thook;
               service_hook_m[alloc_m] = r.shook;
               alloc_m++;
               evs.push_back(slot_event(EV_CREATE, alloc_m - 1, 1'b1));
            end
         end
         REQ_SERVICE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (pending_m[i]) begin
                  pending_m[i] = 1'b0;
                  if (service_hook_m[i] && evs.size() < MAX_RESULTS)
                     evs.push_back(slot_event(EV_SERVICE, i, 1'b0));
               end
            end
         end
         REQ_SET_ENABLE: begin
            if (addressed) enabled_m[r.index] = r.enable;
         end
         REQ_CLEAR: begin
            if (addressed) tick_count_m[r.index] = '0;
         end
         REQ_SET_PERIOD: begin
            if (addressed) period_m[r.index] = r.period;
         end
         REQ_READ_ALLOC: begin
            evs.push_back(slot_event(EV_ALLOC, 0, 1'b0));
         end
         default: begin
         end
      endcase
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[k]) hook_events_due.push_back(evs[k]);
   endtask

   task automatic add_random_items(input int n);
      timer_req_type r;
      int pick;
      int made;
      made = 0;
      while (made < n) begin
         r = req_item(3'($urandom_range(0, 6)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            r.code = REQ_TICK;
         end else if (pick < 52) begin
            r.code = REQ_SERVICE;
         end else if (pick < 60) begin
            r.code = REQ_CREATE;
         end else if (pick < 70) begin
            r.code = REQ_SET_ENABLE;
            r.enable = ($urandom_range(0, 9) < 7);
         end else if (pick < 77) begin
            r.code = REQ_CLEAR;
         end else if (pick < 87) begin
            r.code = REQ_SET_PERIOD;
         end else if (pick < 94) begin
            r.code = REQ_READ_ALLOC;
         end else begin
            r.code = REQ_UNUSED;
         end
         // Short intervals keep expiries frequent; a few long ones exercise the full width.
         if ((r.code == REQ_CREATE || r.code == REQ_SET_PERIOD) && $urandom_range(0, 7) != 0)
            r.period = $urandom_range(0, 6);
         if (r.code != REQ_UNUSED) begin
            made++;
            if (made == DRAIN_AT) r.drain_first = 1'b1;
         end
         request_q.push_back(r);
      end
   endtask

   // Idling is switched off near the end and in every third window of items.
   function automatic bit idling_on(int phase);
      return (items_accepted + 60 < total_items) && ((items_accepted / 64 + phase) % 3 != 0);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_timer_events(offered);
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (hook_events_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("Unexpected result: kind %0d slot %0d ok %0d count %0d last %0d",
                           rsp_event_kind, rsp_slot_index, rsp_create_ok,
                           rsp_allocated_count, rsp_last_event);
            end else begin
               want = hook_events_due.pop_front();
               if (rsp_event_kind !== want.kind || rsp_slot_index !== want.slot ||
                   rsp_create_ok !== want.ok || rsp_allocated_count !== want.count ||
                   rsp_last_event !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("Mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                              want.kind, want.slot, want.ok, want.count, want.last,
                              rsp_event_kind, rsp_slot_index, rsp_create_ok,
                              rsp_allocated_count, rsp_last_event);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain_first && hook_events_due.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         offered = request_q.pop_front();
         req_type <= offered.code;
         req_timer_index <= offered.index;
         req_enable_bit <= offered.enable;
         req_period_value <= offered.period;
         req_has_tick_hook <= offered.thook;
         req_has_service_hook <= offered.shook;
         req_valid <= 1'b1;
         if (idling_on(0) && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 11);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!long_hold_done && items_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on(1) && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_TICK;
      req_timer_index = '0;
      req_enable_bit = 1'b0;
      req_period_value = '0;
      req_has_tick_hook = 1'b0;
      req_has_service_hook = 1'b0;
      rsp_stall = 1'b0;
      errors = 0;
      items_accepted = 0;
      cycles = 0;
      gap_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
      alloc_m = 0;
      for (int i = 0; i < SLOTS; i++) begin
         tick_count_m[i] = '0;
         period_m[i] = '0;
         enabled_m[i] = 1'b0;
         pending_m[i] = 1'b0;
         tick_hook_m[i] = 1'b0;
         service_hook_m[i] = 1'b0;
      end

      // Empty bank: reads, ignored slot writes, quiet tick and service.
      request_q.push_back(req_item(REQ_READ_ALLOC, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_SET_ENABLE, 3'd0, 1'b1, 32'd0, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_SET_PERIOD, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_CLEAR, 3'd3, 1'b0, 32'h5555_AAAA, 1'b0, 1'b1));
      request_q.push_back(req_item(REQ_TICK, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_SERVICE, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      // A zero interval, an interval of two, a disabled slot with the widest interval and a unit interval.
      request_q.push_back(req_item(REQ_CREATE, 3'd5, 1'b1, 32'd0, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'd2, 1'b0, 1'b1));
      request_q.push_back(req_item(REQ_CREATE, 3'd7, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0));
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'd1, 1'b1, 1'b0));
      request_q.push_back(req_item(REQ_TICK, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_SERVICE, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_SET_ENABLE, 3'd2, 1'b1, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_SET_PERIOD, 3'd2, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_TICK, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0));
      request_q.push_back(req_item(REQ_CLEAR, 3'd1, 1'b1, 32'd0, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_UNUSED, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_READ_ALLOC, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      // Fill the bank, then one create too many.
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'd3, 1'b1, 1'b1));
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'd0, 1'b1, 1'b0));
      request_q.push_back(req_item(REQ_CREATE, 3'd0, 1'b1, 32'd1, 1'b0, 1'b1));
      request_q.push_back(req_item(REQ_CREATE, 3'd4, 1'b1, 32'd7, 1'b1, 1'b1));
      add_random_items(RANDOM_ITEMS);
      total_items = request_q.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (request_q.size() != 0 || req_valid || hook_events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0 && hook_events_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
